/* rtl/sti_pkg.sv */
// Shared constants and types for the sorted table insert/delete block.
`timescale 1ns / 1ps
package sti_pkg;

   localparam int CAPACITY    = 16;
   localparam int VALUE_BITS  = 32;
   localparam int IDX_BITS    = $clog2(CAPACITY);
   localparam int CNT_BITS    = $clog2(CAPACITY + 1);
   localparam int STATUS_BITS = 3;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_INSERTED  = 3'd0,
      ST_DELETED   = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

endpackage

/* rtl/sti_if.sv */
// Request and response channel interfaces for the sorted table.
`timescale 1ns / 1ps
interface sti_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  opcode;
   logic signed [sti_pkg::VALUE_BITS-1:0] value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface sti_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic        [sti_pkg::STATUS_BITS-1:0] status;
   logic        [sti_pkg::CNT_BITS-1:0]    entry_count;
   logic signed [sti_pkg::VALUE_BITS-1:0]  smallest_value;
   logic                                   table_empty;

   modport source (output valid, output status, output entry_count,
                   output smallest_value, output table_empty, input ready);
   modport sink   (input valid, input status, input entry_count,
                   input smallest_value, input table_empty, output ready);
endinterface

/* rtl/sorted_table_insert_delete.sv */
// Sorted table of signed values in one memory; insert and delete walk it one entry a cycle.
// Insert walks down from the last entry over those greater than the value; delete walks up
//   from the first entry to the first greater one before a match, else to the last entry.
//   Insert into an empty table writes directly; full insert and empty delete read nothing.
// One transaction at a time; the next request is taken in the cycle after the response is
//   registered; a held response stalls the next one. Reset: synchronous, clears the count.
`timescale 1ns / 1ps
module sorted_table_insert_delete (
   input logic      clock,
   input logic      reset,
   sti_req_if.sink   req_chan,
   sti_rsp_if.source rsp_chan
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SCAN,
      S_WRITE_VAL,
      S_RESULT
   } state_type;

   state_type                              state_ff;
   logic                                   op_ff;
   logic signed [sti_pkg::VALUE_BITS-1:0]  val_ff;
   logic        [sti_pkg::IDX_BITS-1:0]    idx_ff;
   logic        [sti_pkg::CNT_BITS-1:0]    count_ff;
   logic                                   found_ff;
   logic signed [sti_pkg::VALUE_BITS-1:0]  head_ff;
   sti_pkg::status_type                    status_ff;

   logic                                   rsp_valid_ff;
   logic        [sti_pkg::STATUS_BITS-1:0] rsp_status_ff;
   logic        [sti_pkg::CNT_BITS-1:0]    rsp_count_ff;
   logic signed [sti_pkg::VALUE_BITS-1:0]  rsp_smallest_ff;
   logic                                   rsp_empty_ff;

   logic signed [sti_pkg::VALUE_BITS-1:0]  table_mem [sti_pkg::CAPACITY];
   logic signed [sti_pkg::VALUE_BITS-1:0]  rdata_ff;

   logic                                   mem_re;
   logic        [sti_pkg::IDX_BITS-1:0]    mem_raddr;
   logic                                   mem_we;
   logic        [sti_pkg::IDX_BITS-1:0]    mem_waddr;
   logic signed [sti_pkg::VALUE_BITS-1:0]  mem_wdata;

   logic                                   req_fire;
   logic                                   scan_gt;
   logic                                   scan_eq;
   logic                                   scan_last;
   logic                                   found_in;
   logic        [sti_pkg::CNT_BITS-1:0]    last_idx;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign scan_gt   = (rdata_ff > val_ff);
   assign scan_eq   = (rdata_ff == val_ff);
   assign last_idx  = sti_pkg::CNT_BITS'(count_ff - 1'b1);
   assign scan_last = ({1'b0, idx_ff} == sti_pkg::CNT_BITS'(last_idx));
   assign found_in  = found_ff || scan_eq;

   // memory port control
   always_comb begin
      mem_re    = 1'b0;
      mem_raddr = idx_ff;
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = val_ff;
      case (state_ff)
         S_READ: begin
            mem_re = 1'b1;
         end
         S_SCAN: begin
            if (op_ff == sti_pkg::OP_INSERT) begin
               mem_we    = 1'b1;
               mem_waddr = idx_ff + 1'b1;
               mem_wdata = scan_gt ? rdata_ff : val_ff;
               if (scan_gt && (idx_ff != '0)) begin
                  mem_re    = 1'b1;
                  mem_raddr = idx_ff - 1'b1;
               end
            end else begin
               mem_we    = found_ff;
               mem_waddr = idx_ff - 1'b1;
               mem_wdata = rdata_ff;
               if (!(!found_ff && scan_gt) && !scan_last) begin
                  mem_re    = 1'b1;
                  mem_raddr = idx_ff + 1'b1;
               end
            end
         end
         S_WRITE_VAL: begin
            mem_we = 1'b1;
         end
         default: begin
            mem_re = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= table_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready && (state_ff != S_RESULT)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (mem_we && (mem_waddr == '0)) begin
            head_ff <= mem_wdata;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  op_ff    <= req_chan.opcode;
                  val_ff   <= req_chan.value;
                  found_ff <= 1'b0;
                  if (req_chan.opcode == sti_pkg::OP_INSERT) begin
                     if (count_ff == sti_pkg::CNT_BITS'(sti_pkg::CAPACITY)) begin
                        status_ff <= sti_pkg::ST_FULL;
                        state_ff  <= S_RESULT;
                     end else if (count_ff == '0) begin
                        idx_ff   <= '0;
                        state_ff <= S_WRITE_VAL;
                     end else begin
                        idx_ff   <= last_idx[sti_pkg::IDX_BITS-1:0];
                        state_ff <= S_READ;
                     end
                  end else begin
                     if (count_ff == '0) begin
                        status_ff <= sti_pkg::ST_EMPTY;
                        state_ff  <= S_RESULT;
                     end else begin
                        idx_ff   <= '0;
                        state_ff <= S_READ;
                     end
                  end
               end
            end
            S_READ: begin
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (op_ff == sti_pkg::OP_INSERT) begin
                  if (scan_gt) begin
                     if (idx_ff == '0) begin
                        state_ff <= S_WRITE_VAL;
                     end else begin
                        idx_ff <= idx_ff - 1'b1;
                     end
                  end else begin
                     count_ff  <= count_ff + 1'b1;
                     status_ff <= sti_pkg::ST_INSERTED;
                     state_ff  <= S_RESULT;
                  end
               end else begin
                  if (!found_ff && scan_gt) begin
                     status_ff <= sti_pkg::ST_NOT_FOUND;
                     state_ff  <= S_RESULT;
                  end else if (scan_last) begin
                     if (found_in) begin
                        count_ff  <= count_ff - 1'b1;
                        status_ff <= sti_pkg::ST_DELETED;
                     end else begin
                        status_ff <= sti_pkg::ST_NOT_FOUND;
                     end
                     state_ff <= S_RESULT;
                  end else begin
                     found_ff <= found_in;
                     idx_ff   <= idx_ff + 1'b1;
                  end
               end
            end
            S_WRITE_VAL: begin
               count_ff  <= count_ff + 1'b1;
               status_ff <= sti_pkg::ST_INSERTED;
               state_ff  <= S_RESULT;
            end
            S_RESULT: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_status_ff   <= status_ff;
                  rsp_count_ff    <= count_ff;
                  rsp_smallest_ff <= (count_ff == '0) ? '0 : head_ff;
                  rsp_empty_ff    <= (count_ff == '0);
                  state_ff        <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.entry_count    = rsp_count_ff;
   assign rsp_chan.smallest_value = rsp_smallest_ff;
   assign rsp_chan.table_empty    = rsp_empty_ff;

endmodule

/* rtl/sti_checker.sv */
// Port-level checks for the sorted table, bound to the top level.
`timescale 1ns / 1ps
module sti_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic        [sti_pkg::STATUS_BITS-1:0] rsp_status,
   input logic        [sti_pkg::CNT_BITS-1:0]    rsp_entry_count,
   input logic signed [sti_pkg::VALUE_BITS-1:0]  rsp_smallest_value,
   input logic                                   rsp_table_empty
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_table_empty == (rsp_entry_count == '0)))
      else $error("empty flag disagrees with entry count");

   a_empty_smallest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_empty |-> (rsp_smallest_value == '0))
      else $error("smallest value nonzero on empty table");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == sti_pkg::ST_FULL) |->
      (rsp_entry_count == sti_pkg::CNT_BITS'(sti_pkg::CAPACITY)))
      else $error("full status with table not full");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == sti_pkg::ST_EMPTY) |-> rsp_table_empty)
      else $error("empty status with entries present");

endmodule

bind sorted_table_insert_delete sti_checker u_sti_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_status         (rsp_chan.status),
   .rsp_entry_count    (rsp_chan.entry_count),
   .rsp_smallest_value (rsp_chan.smallest_value),
   .rsp_table_empty    (rsp_chan.table_empty)
);

/* dv/sorted_table_insert_delete_checker.sv */
// Checker for the sorted table: predicts each response from accepted requests and compares.
`timescale 1ns / 1ps
module sorted_table_insert_delete_checker
   import sti_pkg::*;
(
   input  logic clock,
   input  logic reset,
   sti_req_if   req_mon,
   sti_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_count
);

   typedef logic signed [VALUE_BITS-1:0] value_type;

   typedef struct {
      status_type          status;
      logic [CNT_BITS-1:0] count;
      value_type           smallest;
      logic                empty;
   } table_result_type;

   value_type        sorted_q[$];
   table_result_type expected_rsp_q[$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      fail_count++;
   endtask

   function automatic table_result_type apply_table_op(input opcode_type op,
                                                       input value_type val);
      table_result_type res;
      int               pos;
      int               idx;
      if (op == OP_INSERT) begin
         if (sorted_q.size() >= CAPACITY) begin
            res.status = ST_FULL;
         end else begin
            pos = 0;
            while (pos < sorted_q.size() && sorted_q[pos] <= val)
               pos++;
            sorted_q.insert(pos, val);
            res.status = ST_INSERTED;
         end
      end else if (sorted_q.size() == 0) begin
         res.status = ST_EMPTY;
      end else begin
         idx = -1;
         for (int i = sorted_q.size() - 1; i >= 0 && idx < 0; i--)
            if (sorted_q[i] == val)
               idx = i;
         if (idx < 0) begin
            res.status = ST_NOT_FOUND;
         end else begin
            sorted_q.delete(idx);
            res.status = ST_DELETED;
         end
      end
      res.count    = CNT_BITS'(sorted_q.size());
      res.smallest = (sorted_q.size() > 0) ? sorted_q[0] : '0;
      res.empty    = (sorted_q.size() == 0);
      return res;
   endfunction

   always @(posedge clock) begin
      table_result_type want;
      if (reset) begin
         sorted_q.delete();
         expected_rsp_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            expected_rsp_q.push_back(apply_table_op(opcode_type'(req_mon.opcode),
                                                    req_mon.value));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch($sformatf("response with no transaction pending, status %0d",
                                         rsp_mon.status));
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_mon.status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_mon.status, want.status));
               if (rsp_mon.entry_count !== want.count)
                  report_mismatch($sformatf("entry_count got %0d want %0d",
                                            rsp_mon.entry_count, want.count));
               if (rsp_mon.smallest_value !== want.smallest)
                  report_mismatch($sformatf("smallest_value got %0d want %0d",
                                            rsp_mon.smallest_value, want.smallest));
               if (rsp_mon.table_empty !== want.empty)
                  report_mismatch($sformatf("table_empty got %0b want %0b",
                                            rsp_mon.table_empty, want.empty));
            end
         end
      end
      pending_count = expected_rsp_q.size();
   end

endmodule

/* dv/sorted_table_insert_delete_tb.sv */
// Testbench top for the sorted table: clock, reset, request and response traffic, verdict.
`timescale 1ns / 1ps
module sorted_table_insert_delete_tb;
   import sti_pkg::*;

   localparam int IDLE_LIMIT  = 2000;
   localparam int HOLD_CYCLES = 80;
   localparam int PHASE_ITEMS = 130;

   localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   send_idle_pct;
   int   rsp_idle_pct;
   bit   hold_request;
   int   hold_left;
   int   stall_cycles;

   logic signed [VALUE_BITS-1:0] value_pool[8];

   sti_req_if req_bus ();
   sti_rsp_if rsp_bus ();

   sorted_table_insert_delete dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   sorted_table_insert_delete_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   initial begin
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.opcode = OP_INSERT;
      req_bus.value  = '0;
      rsp_bus.ready  = 1'b0;
      send_idle_pct  = 14;
      rsp_idle_pct   = 45;
      hold_request   = 1'b0;
      hold_left      = 0;
      stall_cycles   = 0;
   end

   // receiver: random back-pressure, plus one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_item(input opcode_type op, input logic signed [VALUE_BITS-1:0] val);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.opcode <= op;
      req_bus.value  <= val;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   function automatic logic signed [VALUE_BITS-1:0] pick_value();
      if ($urandom_range(99) < 6) begin
         case ($urandom_range(3))
            0:       value_pool[$urandom_range(7)] = VAL_MIN;
            1:       value_pool[$urandom_range(7)] = VAL_MAX;
            2:       value_pool[$urandom_range(7)] = $signed($urandom_range(20)) - 10;
            default: value_pool[$urandom_range(7)] = $urandom;
         endcase
      end
      if ($urandom_range(99) < 70)
         return value_pool[$urandom_range(7)];
      return $urandom;
   endfunction

   initial begin
      bit         filling;
      int         insert_pct;
      opcode_type op;
      value_pool = '{VAL_MIN, VAL_MAX, 0, -1, 1, 5, -5, 100};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty delete, extremes, duplicates, not found, fill to full
      send_item(OP_DELETE, VAL_MIN);
      send_item(OP_INSERT, VAL_MIN);
      send_item(OP_INSERT, VAL_MAX);
      send_item(OP_INSERT, 0);
      send_item(OP_INSERT, 0);
      send_item(OP_INSERT, -1);
      send_item(OP_DELETE, 5);
      send_item(OP_DELETE, 0);
      send_item(OP_DELETE, VAL_MAX);
      send_item(OP_DELETE, VAL_MIN);
      for (int i = 0; i < CAPACITY - 1; i++)
         send_item(OP_INSERT, $urandom);

      filling = 1'b0;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 14; rsp_idle_pct = 45; end
            1: begin send_idle_pct = 45; rsp_idle_pct = 14; end
            default: begin send_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 20 == 0)
               filling = ~filling;
            insert_pct = filling ? 75 : 25;
            op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_DELETE;
            send_item(op, pick_value());
            if (phase == 2 && n == 0)
               hold_request = 1'b1;
         end
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
